// ===== rtl/core/fas_pkg.sv =====
// Shared types and constants for the frame animation stepper.
package fas_pkg;

   localparam int MAX_FRAMES = 1024;
   localparam int CNT_W      = 11;   // frame count, 1..MAX_FRAMES
   localparam int FRM_W      = 10;   // zero-based frame index
   localparam int DVD_W      = 17;   // magnitude of (frame_now - 1)
   localparam int STEP_W     = 5;    // divider step counter

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_FRAME_PERIOD = 3'd0;
   localparam logic [2:0] REG_FRAME_COUNT  = 3'd1;
   localparam logic [2:0] REG_LOOP_START   = 3'd2;
   localparam logic [2:0] REG_LOOP_END     = 3'd3;
   localparam logic [2:0] REG_LOOP_ENABLE  = 3'd4;

   typedef struct packed {
      logic signed [25:0] frame_period;
      logic [CNT_W-1:0]   frame_count;
      logic [15:0]        loop_start;
      logic [15:0]        loop_end;
      logic               loop_enable;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [FRM_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== rtl/core/fas_csr.sv =====
// Configuration register file with APB-style access.
module fas_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output fas_pkg::cfg_type  cfg
);
   import fas_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_FRAME_PERIOD: cfg_in.frame_period = csr_pwdata[25:0];
            REG_FRAME_COUNT:  cfg_in.frame_count  = csr_pwdata[CNT_W-1:0];
            REG_LOOP_START:   cfg_in.loop_start   = csr_pwdata[15:0];
            REG_LOOP_END:     cfg_in.loop_end     = csr_pwdata[15:0];
            REG_LOOP_ENABLE:  cfg_in.loop_enable  = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_period <= 26'sd4369;
         cfg_ff.frame_count  <= CNT_W'(1);
         cfg_ff.loop_start   <= 16'd1;
         cfg_ff.loop_end     <= 16'd0;
         cfg_ff.loop_enable  <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_FRAME_PERIOD: csr_prdata = {{6{cfg_ff.frame_period[25]}}, cfg_ff.frame_period};
         REG_FRAME_COUNT:  csr_prdata = {{(32-CNT_W){1'b0}}, cfg_ff.frame_count};
         REG_LOOP_START:   csr_prdata = {16'd0, cfg_ff.loop_start};
         REG_LOOP_END:     csr_prdata = {16'd0, cfg_ff.loop_end};
         REG_LOOP_ENABLE:  csr_prdata = {31'd0, cfg_ff.loop_enable};
         default:          csr_prdata = 32'd0;
      endcase
   end

endmodule

// ===== rtl/core/fas_divider.sv =====
// Restoring serial remainder unit, one dividend bit per cycle.
module fas_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  fas_pkg::div_req_type req,
   output fas_pkg::div_rsp_type rsp
);
   import fas_pkg::*;

   logic [FRM_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  r_wide;
   logic [CNT_W-1:0]  r_next;

   // partial remainder stays below the divisor, so it fits FRM_W bits
   always_comb begin
      r_wide  = {rem_ff, dvd_ff[DVD_W-1]};
      r_next  = (r_wide >= dsr_ff) ? (r_wide - dsr_ff) : r_wide;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
         cnt_in  = STEP_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = r_next[FRM_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ===== rtl/core/frame_animation_stepper_core.sv =====
// Top level of the frame animation stepper: sequencer, accumulator, result register.
// An accepted tick goes through the accumulate and compare states, and through the
// 17-step serial remainder unit when a frame step is due, before the result is formed.
// One tick is in flight at a time; the next tick is taken while a result waits.
// Reset (synchronous, active high): accumulator cleared, registers to defaults, no result.
module frame_animation_stepper_core (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: elapsed[23:0], is_playing[24], frame_now[40:25], zero pad [47:41]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // rsp_tdata: frame_next[15:0], still_playing[16], frame_changed[17], looped[18],
   //            ended[19], zero pad [23:20]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import fas_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ACC  = 3'd1;   // saturating add of elapsed time
   localparam logic [2:0] S_CMP  = 3'd2;   // compare against period, launch remainder
   localparam logic [2:0] S_DIV  = 3'd3;   // wait for serial remainder
   localparam logic [2:0] S_FIN  = 3'd4;   // form result, update accumulator

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [2:0]  state_ff, state_in;
   logic [23:0] elapsed_ff;
   logic        playing_ff;
   logic [15:0] fnow_ff;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] frame_time_ff, frame_time_in;
   logic        due_ff, due_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             fin_fire;
   logic [CNT_W-1:0] n_frames;
   logic [FRM_W-1:0] first_frame;
   logic [FRM_W-1:0] last_frame;
   logic [25:0]      mag;
   logic             forward;
   logic [32:0]      sum_wide;
   logic [31:0]      sum_sat;
   logic [DVD_W-1:0] x_val;
   logic             x_neg;
   logic [FRM_W-1:0] cur;
   logic             at_end;
   logic [15:0]      next_frame;
   logic             still, changed, looped, ended;

   fas_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fas_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign fin_fire   = (state_ff == S_FIN) & (~rsp_valid_ff | rsp_tready);

   // clamped count and loop bounds; the user must keep config stable while an item is in flight (not enforced here)
   always_comb begin
      if (cfg.frame_count == '0)
         n_frames = CNT_W'(1);
      else if (cfg.frame_count > CNT_W'(MAX_FRAMES))
         n_frames = CNT_W'(MAX_FRAMES);
      else
         n_frames = cfg.frame_count;

      if (cfg.loop_start == 16'd0 || cfg.loop_start > 16'(n_frames))
         first_frame = '0;
      else
         first_frame = FRM_W'(cfg.loop_start - 16'd1);

      if (cfg.loop_end == 16'd0 || cfg.loop_end > 16'(n_frames))
         last_frame = FRM_W'(n_frames - CNT_W'(1));
      else
         last_frame = FRM_W'(cfg.loop_end - 16'd1);
   end

   // period magnitude and direction; zero period steps backward
   assign mag     = cfg.frame_period[25] ? (26'd0 - cfg.frame_period) : cfg.frame_period;
   assign forward = ~cfg.frame_period[25] & (cfg.frame_period != 26'sd0);

   assign sum_wide = {1'b0, frame_time_ff} + {9'd0, elapsed_ff};
   assign sum_sat  = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];

   // zero-based current frame: |frame_now - 1| mod n, negatives wrapped up
   assign x_val = {fnow_ff[15], fnow_ff} - DVD_W'(1);
   assign x_neg = x_val[DVD_W-1];

   assign div_req.start    = (state_ff == S_CMP) & due_in;
   assign div_req.dividend = x_neg ? (DVD_W'(0) - x_val) : x_val;
   assign div_req.divisor  = n_frames;

   assign cur = (x_neg && div_rsp.remainder != '0)
                ? FRM_W'(n_frames - {1'b0, div_rsp.remainder})
                : div_rsp.remainder;

   // result of a tick
   always_comb begin
      next_frame = fnow_ff;
      still      = playing_ff;
      changed    = 1'b0;
      looped     = 1'b0;
      ended      = 1'b0;
      at_end     = forward ? (cur == last_frame) : (cur == first_frame);
      frame_time_in = frame_time_ff;
      if (playing_ff) begin
         frame_time_in = acc_ff;
         if (due_ff) begin
            if (at_end) begin
               if (cfg.loop_enable) begin
                  next_frame = forward ? (16'(first_frame) + 16'd1)
                                       : (16'(last_frame) + 16'd1);
                  changed = 1'b1;
                  looped  = 1'b1;
               end else begin
                  still         = 1'b0;
                  ended         = 1'b1;
                  frame_time_in = '0;
               end
            end else begin
               // off the loop end: plain step, may land on 0 or count+1
               next_frame = forward ? (16'(cur) + 16'd2) : 16'(cur);
               changed    = 1'b1;
            end
         end
      end
      if (!fin_fire)
         frame_time_in = frame_time_ff;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      due_in   = due_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept)
               state_in = S_ACC;
         end
         S_ACC: begin
            acc_in   = sum_sat;
            state_in = S_CMP;
         end
         S_CMP: begin
            due_in = playing_ff & (acc_ff > {6'd0, mag});
            if (due_in) begin
               acc_in   = acc_ff - {6'd0, mag};
               state_in = S_DIV;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DIV: begin
            if (div_rsp.done)
               state_in = S_FIN;
         end
         S_FIN: begin
            if (fin_fire)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register: holds a result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fin_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'd0, ended, looped, changed, still, next_frame};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         frame_time_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         due_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         frame_time_ff <= frame_time_in;
         rsp_valid_ff  <= rsp_valid_in;
         due_ff        <= due_in;
      end
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         elapsed_ff <= req_tdata[23:0];
         playing_ff <= req_tdata[24];
         fnow_ff    <= req_tdata[40:25];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for frame_animation_stepper_core: tick stimulus, predictor, scoreboard.
module testbench;
   import fas_pkg::*;

   // Cycles with no handshake anywhere before the run is declared hung. The longest
   // legal quiet stretch is the long receiver hold plus a short stall run.
   localparam int QUIET_LIMIT = 4000;
   // Cycles kept after the last result, so a stray extra result still shows up
   // as an unexpected one.
   localparam int TAIL_CYCLES = 40;
   // Hold-off used to back the block up until it stops taking ticks.
   localparam int HOLD_CYCLES = 300;
   // Register slot past the last register: a write there must change nothing.
   localparam logic [2:0] REG_UNUSED = 3'd7;

   // req_tdata: elapsed[23:0], is_playing[24], frame_now[40:25], zero pad [47:41]
   typedef struct packed {
      logic [6:0]         pad;
      logic signed [15:0] frame_now;
      logic               is_playing;
      logic [23:0]        elapsed;
   } tick_req_type;

   // rsp_tdata: frame_next[15:0], still_playing[16], frame_changed[17], looped[18],
   //            ended[19], zero pad [23:20]
   typedef struct packed {
      logic [3:0]         pad;
      logic               ended;
      logic               looped;
      logic               frame_changed;
      logic               still_playing;
      logic signed [15:0] frame_next;
   } tick_rsp_type;

   // Predicts each tick from its own copy of the registers and the time accumulator,
   // keeps the expected results in order and checks what the block returns.
   class tick_scoreboard_type;
      cfg_type            cfg;
      logic [31:0]        frame_time;
      tick_rsp_type       expected_q[$];
      logic signed [15:0] last_frame;
      logic               last_still;
      int errors, ticks, results, steps, wraps, stops, saturations;

      function void reset_state();
         cfg.frame_period = 26'sd4369;
         cfg.frame_count  = 11'd1;
         cfg.loop_start   = 16'd1;
         cfg.loop_end     = 16'd0;
         cfg.loop_enable  = 1'b1;
         frame_time = '0;
         last_frame = 16'sd1;
         last_still = 1'b1;
         expected_q.delete();
      endfunction

      function void set_reg(input logic [2:0] idx, input logic [31:0] value);
         case (idx)
            REG_FRAME_PERIOD: cfg.frame_period = value[25:0];
            REG_FRAME_COUNT:  cfg.frame_count  = value[CNT_W-1:0];
            REG_LOOP_START:   cfg.loop_start   = value[15:0];
            REG_LOOP_END:     cfg.loop_end     = value[15:0];
            REG_LOOP_ENABLE:  cfg.loop_enable  = value[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // One accepted tick: advance the accumulator and work out the frame step.
      function void note_input(input tick_req_type req);
         logic [63:0]  sum;
         logic [31:0]  mag;
         tick_rsp_type r;
         int per, n, first, last, cur, fnow;
         r = '0;
         r.frame_next    = req.frame_now;
         r.still_playing = req.is_playing;
         if (req.is_playing) begin
            sum = {32'd0, frame_time} + {40'd0, req.elapsed};
            if (sum > 64'h0000_0000_FFFF_FFFF) begin
               sum = 64'h0000_0000_FFFF_FFFF;
               saturations++;
            end
            frame_time = sum[31:0];
            per = cfg.frame_period;
            mag = (per < 0) ? -per : per;
            if (frame_time > mag) begin
               steps++;
               frame_time = frame_time - mag;
               n = cfg.frame_count;
               if (n < 1) n = 1;
               if (n > MAX_FRAMES) n = MAX_FRAMES;
               first = cfg.loop_start;
               first = first - 1;
               if (first < 0 || first >= n) first = 0;
               last = cfg.loop_end;
               last = last - 1;
               if (last < 0 || last >= n) last = n - 1;
               fnow = req.frame_now;
               cur = (fnow - 1) % n;
               if (cur < 0) cur += n;
               if ((per > 0 && cur == last) || (per <= 0 && cur == first)) begin
                  if (cfg.loop_enable) begin
                     r.frame_next    = 16'((per > 0) ? first + 1 : last + 1);
                     r.frame_changed = 1'b1;
                     r.looped        = 1'b1;
                     wraps++;
                  end else begin
                     r.still_playing = 1'b0;
                     r.ended         = 1'b1;
                     frame_time      = '0;
                     stops++;
                  end
               end else begin
                  r.frame_next    = 16'((per > 0) ? cur + 2 : cur);
                  r.frame_changed = 1'b1;
               end
            end
         end
         expected_q.insert(expected_q.size(), r);
         last_frame = r.frame_next;
         last_still = r.still_playing;
         ticks++;
      endfunction

      task report(input string what);
         errors++;
         if (errors <= 200) $display("MISMATCH: %s", what);
      endtask

      task check_result(input tick_rsp_type got);
         tick_rsp_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result %0d arrived with no tick outstanding", results));
            return;
         end
         want = expected_q.pop_front();
         if (got.frame_next !== want.frame_next)
            report($sformatf("result %0d frame_next got %0d want %0d",
                             results, got.frame_next, want.frame_next));
         if (got.still_playing !== want.still_playing)
            report($sformatf("result %0d still_playing got %b want %b",
                             results, got.still_playing, want.still_playing));
         if (got.frame_changed !== want.frame_changed)
            report($sformatf("result %0d frame_changed got %b want %b",
                             results, got.frame_changed, want.frame_changed));
         if (got.looped !== want.looped)
            report($sformatf("result %0d looped got %b want %b",
                             results, got.looped, want.looped));
         if (got.ended !== want.ended)
            report($sformatf("result %0d ended got %b want %b",
                             results, got.ended, want.ended));
         if (got.pad !== 4'd0)
            report($sformatf("result %0d pad bits got %b", results, got.pad));
         results++;
      endtask

      task close_out();
         if (expected_q.size() != 0)
            report($sformatf("%0d ticks never produced a result", expected_q.size()));
      endtask
   endclass

   // Every input starts at a known value; reset is held from time zero.
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [4:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tick_scoreboard_type sb;
   int  send_pct;          // percent of cycles the sender holds back a tick
   int  stall_pct;         // percent of cycles the receiver drops rsp_tready
   bit  hold_armed;        // request for one long receiver hold-off
   int  hold_left;
   int  quiet_cycles;
   int  settings;

   frame_animation_stepper_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // Receiver: random back-pressure, plus one long hold-off counted here so the
   // block fills up and has to refuse ticks while the sender keeps offering.
   always @(posedge clock) begin
      if (hold_armed && hold_left == 0) begin
         hold_left  = HOLD_CYCLES;
         hold_armed = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Results are sampled at the edge, before any flop of this edge updates.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Watchdog: any handshake on any port counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no handshake for %0d cycles", QUIET_LIMIT);
         $display("frame_animation_stepper_core verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One register write: setup cycle, then access until pready. psel stays up so
   // back-to-back writes never assign a signal twice in one step.
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, value);
   endtask

   task automatic write_config(input int period, input int count, input int lo,
                               input int hi, input bit enable);
      write_reg(REG_FRAME_PERIOD, period);
      write_reg(REG_FRAME_COUNT, count);
      write_reg(REG_LOOP_START, lo);
      write_reg(REG_LOOP_END, hi);
      write_reg(REG_LOOP_ENABLE, 32'(enable));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      settings++;
   endtask

   // Offer one tick, with random gaps before it, and log it once it is taken.
   task automatic send_tick(input tick_req_type item);
      while (send_pct != 0 && $urandom_range(99) < send_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      do @(posedge clock); while (!req_tready);
      sb.note_input(item);
   endtask

   task automatic play_tick(input logic [23:0] el, input bit pl, input logic signed [15:0] fr);
      tick_req_type t;
      t = '0;
      t.elapsed    = el;
      t.is_playing = pl;
      t.frame_now  = fr;
      send_tick(t);
   endtask

   // Stop offering and wait until every predicted result has been returned.
   // Each tick always gives a result, so the block is idle afterwards.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_pct = 0;  stall_pct = 0;  end
         1: begin send_pct = 62; stall_pct = 0;  end
         2: begin send_pct = 0;  stall_pct = 62; end
         default: begin send_pct = 36; stall_pct = 36; end
      endcase
   endtask

   // Well-formed play: feed the last frame and play flag back in, with elapsed
   // time scaled to the period. Otherwise noise over the whole field ranges.
   function automatic tick_req_type make_tick(input bit follow, input int span, input int count);
      tick_req_type t;
      t = '0;
      if (follow) begin
         t.frame_now  = sb.last_frame;
         t.is_playing = sb.last_still || ($urandom_range(3) == 0);
         t.elapsed    = 24'($urandom_range(span));
      end else begin
         t.elapsed    = 24'($urandom);
         t.is_playing = 1'($urandom_range(1));
         t.frame_now  = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(count + 3) - 1);
      end
      return t;
   endfunction

   // Random register setting: mostly short animations so loop ends come often,
   // with period, count and bound extremes mixed in.
   task automatic random_config(output int span, output int count);
      int per, mag, lo, hi;
      case ($urandom_range(9))
         0: per = -(1 << 25);
         1: per = (1 << 25) - 1;
         2: per = 1 << 24;
         3: per = -(1 << 24);
         4: per = $urandom_range(1) ? 0 : -1;
         default: per = $urandom_range(1, 'h30000) * ($urandom_range(1) ? 1 : -1);
      endcase
      case ($urandom_range(7))
         0: count = 0;
         1: count = 1024 + $urandom_range(1023);
         2: count = 1024;
         default: count = $urandom_range(1, 12);
      endcase
      lo = ($urandom_range(5) == 0) ? 16'($urandom) : $urandom_range(count + 1);
      hi = ($urandom_range(5) == 0) ? 16'($urandom) : $urandom_range(count + 1);
      write_config(per, count, lo, hi, $urandom_range(3) != 0);
      mag  = (per < 0) ? -per : per;
      span = (2 * mag + 2 > 'hFFFFFF) ? 'hFFFFFF : 2 * mag + 2;
   endtask

   initial begin
      tick_req_type t;
      int span, count;
      sb = new();
      sb.reset_state();
      set_idling(0);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset defaults first (single frame, wraps onto itself).
      play_tick(24'hFFFFFF, 1'b0, -16'sd32768);   // not playing, max elapsed
      play_tick(24'h000000, 1'b1, 16'sd1);        // no step due
      play_tick(24'd4370, 1'b1, 16'sd32767);      // step on a one-frame loop
      drain();

      // Forward over frames 2..4 of 5; the unused register slot must be ignored.
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      write_config(32'h10000, 5, 2, 4, 1'b1);
      play_tick(24'h10000, 1'b1, 16'sd2);         // plain step forward
      play_tick(24'h10000, 1'b1, 16'sd4);         // loop end wraps to start
      play_tick(24'h10000, 1'b1, 16'sd5);         // outside loop, reaches count+1
      play_tick(24'h10000, 1'b1, 16'sd0);         // negative remainder wraps up
      play_tick(24'h10000, 1'b1, -16'sd32768);
      play_tick(24'h10000, 1'b1, 16'sd32767);
      play_tick(24'hFFFFFF, 1'b1, 16'sd1);
      drain();

      // Backward with stop: ends at the loop start and clears the accumulator.
      write_config(-32'sh10000, 7, 3, 0, 1'b0);
      play_tick(24'h000000, 1'b1, 16'sd3);
      play_tick(24'h010000, 1'b1, 16'sd3);        // accumulator was cleared
      play_tick(24'h000001, 1'b1, 16'sd1);        // outside loop, steps down to 0
      drain();

      // Zero period, count 0 taken as 1, both bounds out of range.
      write_config(0, 0, 0, 16'hFFFF, 1'b1);
      play_tick(24'h000001, 1'b1, 16'sd7);
      play_tick(24'h000000, 1'b1, 16'sd5);
      drain();

      // Most negative period, count above the maximum, stop enabled.
      write_config(32'h0200_0000, 11'h7FF, 1024, 1023, 1'b0);
      play_tick(24'hFFFFFF, 1'b1, 16'sd1024);
      play_tick(24'hFFFFFF, 1'b1, 16'sd1024);
      play_tick(24'hFFFFFF, 1'b1, 16'sd1025);
      drain();

      // Largest positive period, loop start out of range, stop at the last frame.
      write_config(32'h01FF_FFFF, 1024, 16'hFFFF, 1024, 1'b0);
      play_tick(24'hFFFFFF, 1'b1, 16'sd1024);
      play_tick(24'hFFFFFF, 1'b1, 16'sd1024);
      play_tick(24'hFFFFFF, 1'b1, 16'sd1024);
      drain();

      // Random phases, cycling through the idling patterns. One phase without
      // idling carries the long receiver hold; another pauses mid-way for a drain.
      for (int p = 0; p < 8; p++) begin
         set_idling(p % 4);
         random_config(span, count);
         for (int k = 0; k < 46; k++) begin
            if (p == 4 && k == 8) hold_armed = 1'b1;
            if (p == 5 && k == 23) drain();
            send_tick(make_tick($urandom_range(3) != 0, span, count));
         end
         drain();
      end

      // Saturation: near-maximum elapsed with a tiny period pushes the accumulator
      // past 32 bits; the frame keeps stepping around a looping range meanwhile.
      set_idling(1);
      write_config($urandom_range(2) - 1, 12, 3, 9, 1'b1);
      for (int k = 0; k < 280; k++) begin
         t = make_tick(1'b1, 0, 12);
         t.elapsed    = 24'hFF0000 | 24'($urandom_range('hFFFF));
         t.is_playing = 1'b1;
         send_tick(t);
      end
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      sb.close_out();
      $display("run covered %0d ticks under %0d register settings: %0d steps, %0d wraps,",
               sb.ticks, settings, sb.steps, sb.wraps);
      $display("%0d stops at the loop end, %0d saturated sums, %0d results checked",
               sb.stops, sb.saturations, sb.results);
      if (sb.errors == 0) begin
         $display("frame_animation_stepper_core verification clean");
      end else begin
         $display("frame_animation_stepper_core verification failed");
      end
      $finish;
   end

endmodule
